@@ rtl/core/lfp_pkg.sv @@
// Shared types, constants and the gamma table of the LED flash pattern player.
`default_nettype none

package lfp_pkg;

	// pattern geometry
	localparam int PATTERN_LENGTH = 32;
	localparam int POS_W          = $clog2(PATTERN_LENGTH);
	localparam int PAT_WORDS      = 4;
	localparam int PAT_WORD_W     = 64;
	localparam int PAT_BITS       = PAT_WORDS * PAT_WORD_W;
	localparam int CHAR_W         = 8;

	// configuration port
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;

	// field and state widths
	localparam int RAND_W   = 16;
	localparam int PERIOD_W = 10;
	localparam int PEAK_W   = 15;
	localparam int DELAY_W  = 15;
	localparam int LEVEL_W  = 7;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW      = 3'd0,
		REG_PAT_MID_LOW  = 3'd1,
		REG_PAT_MID_HIGH = 3'd2,
		REG_PAT_HIGH     = 3'd3,
		REG_PERIOD       = 3'd4,
		REG_PEAK         = 3'd5
	} reg_idx_t;

	// pattern characters
	localparam logic [CHAR_W-1:0] CH_1    = 8'h31;
	localparam logic [CHAR_W-1:0] CH_9    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_A    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_B    = 8'h42;
	localparam logic [CHAR_W-1:0] CH_R    = 8'h52;
	localparam logic [CHAR_W-1:0] CH_S    = 8'h53;
	localparam logic [CHAR_W-1:0] CH_T    = 8'h54;
	localparam logic [CHAR_W-1:0] CH_U    = 8'h55;
	localparam logic [CHAR_W-1:0] CH_W    = 8'h57;
	localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_Y    = 8'h59;
	localparam logic [CHAR_W-1:0] CH_Z    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;

	// random reductions: levels 10..99, branch odds 49 of 99, delays 1..29 periods
	localparam int LEVEL_SPAN   = 90;
	localparam int LEVEL_BASE   = 10;
	localparam int LEVEL_FULL   = 100;
	localparam int BRANCH_SPAN  = 99;
	localparam int BRANCH_LIMIT = 49;
	localparam int DELAY_SPAN   = 29;
	localparam int RECIP_SHIFT  = 22;
	localparam int RECIP_W      = 24;
	localparam logic [RECIP_W-1:0] RECIP_LEVEL  =
		RECIP_W'(((1 << RECIP_SHIFT) + LEVEL_SPAN - 1) / LEVEL_SPAN);
	localparam logic [RECIP_W-1:0] RECIP_BRANCH =
		RECIP_W'(((1 << RECIP_SHIFT) + BRANCH_SPAN - 1) / BRANCH_SPAN);
	localparam logic [RECIP_W-1:0] RECIP_DELAY  =
		RECIP_W'(((1 << RECIP_SHIFT) + DELAY_SPAN - 1) / DELAY_SPAN);

	// gamma curve, Q30 fractions
	localparam int GAMMA_TENTHS = 22;
	localparam int GAMMA_ROOT   = 10;
	localparam int Q_SHIFT      = 30;
	localparam int GFRAC_W      = Q_SHIFT + 1;
	localparam int LUT_DEPTH    = 1 << LEVEL_W;
	localparam longint unsigned Q_ONE  = 64'd1 << Q_SHIFT;
	localparam longint unsigned Q_HALF = 64'd1 << (Q_SHIFT - 1);

	typedef logic [GFRAC_W-1:0] gamma_lut_t [LUT_DEPTH];

	// current update carried to the output stage
	typedef enum logic [1:0] {
		ACT_KEEP,
		ACT_ZERO,
		ACT_LOAD
	} act_t;

	// one accepted word after random reduction
	typedef struct packed {
		logic                op;
		logic [LEVEL_W-1:0]  lvl_rem;
		logic                branch_home;
		logic [4:0]          delay_rem;
	} in_word_t;

	// result of the sequencer step
	typedef struct packed {
		act_t               act;
		logic [GFRAC_W-1:0] gfrac;
		logic               lit;
		logic               stopped;
	} step_t;

	function automatic longint unsigned q_power(longint unsigned x, int n);
		longint unsigned y;
		int              i;
		y = Q_ONE;
		for (i = 0; i < n; i++)
			y = (y * x + Q_HALF) >> Q_SHIFT;
		return y;
	endfunction

	// level -> gamma fraction, evaluated at elaboration
	function automatic gamma_lut_t build_gamma_lut();
		gamma_lut_t      lut;
		longint unsigned f;
		longint unsigned t;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		int              lvl;
		int              k;
		for (lvl = 0; lvl < LUT_DEPTH; lvl++) begin
			lut[lvl] = '0;
			if (lvl > 0 && lvl <= LEVEL_FULL) begin
				f  = ((64'(lvl) << Q_SHIFT) + 64'(LEVEL_FULL / 2)) / LEVEL_FULL;
				t  = q_power(f, GAMMA_TENTHS);
				lo = 0;
				hi = Q_ONE;
				for (k = 0; k <= Q_SHIFT + 1; k++) begin
					if (lo < hi) begin
						mid = lo + ((hi - lo + 1) >> 1);
						if (q_power(mid, GAMMA_ROOT) <= t)
							lo = mid;
						else
							hi = mid - 1;
					end
				end
				lut[lvl] = GFRAC_W'(lo);
			end
		end
		return lut;
	endfunction

	localparam gamma_lut_t GAMMA_LUT = build_gamma_lut();

endpackage

`default_nettype wire

@@ rtl/core/led_flash_pattern_player_top.sv @@
// Top level of the LED flash pattern player: configuration registers and the three stages.
//
// The player steps through a 32-character pattern, one character per tick word
// (operation 0) while no delay runs; a word with operation 1 restarts the pattern. Every
// accepted word returns exactly one result word: led_on, led_current in milliamps and
// stopped. One word is accepted in every cycle while in_stall is low, and its result
// passes through the input register, the sequencer register and the output register;
// the loops are the sequencer state (position, pass toggle, delay count, lit) and the
// held current of the output stage. The random value is reduced in front of the input
// register, the level is looked up in a constant gamma table in the sequencer stage,
// and the one multiply by peak_current sits in the output stage.
// in_stall rises only when all three stages hold words and out_stall is high.
// Write the configuration only while no word is in flight. Register indexes:
// 0..3 pattern characters (character 0 in bits 7:0 of index 0), 4 ticks_per_period,
// 5 peak_current; indexes 6 and 7 are ignored.
`default_nettype none

module led_flash_pattern_player_top
	import lfp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 operation,
	input  wire logic [RAND_W-1:0]    random_value,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      led_on,
	output logic [PEAK_W-1:0]         led_current,
	output logic                      stopped,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic [PAT_WORD_W-1:0] pattern_q [PAT_WORDS];
	logic [PERIOD_W-1:0]   period_q;
	logic [PEAK_W-1:0]     peak_q;
	logic [PAT_BITS-1:0]   pattern_flat;

	logic     word_valid;
	logic     word_stall;
	in_word_t word;
	logic     step_valid;
	logic     step_stall;
	step_t    step;

	// configuration register bank; unused indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAT_WORDS; i++) begin
				pattern_q[i] <= '0;
			end
			period_q <= PERIOD_RESET;
			peak_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				REG_PAT_LOW, REG_PAT_MID_LOW, REG_PAT_MID_HIGH, REG_PAT_HIGH: begin
					pattern_q[cfg_index[1:0]] <= cfg_data;
				end
				REG_PERIOD: begin
					period_q <= cfg_data[PERIOD_W-1:0];
				end
				REG_PEAK: begin
					peak_q <= cfg_data[PEAK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// character n sits at bits 8n+7:8n of the flat pattern
	always_comb begin
		for (int i = 0; i < PAT_WORDS; i++) begin
			pattern_flat[i*PAT_WORD_W +: PAT_WORD_W] = pattern_q[i];
		end
	end

	// register the word and reduce the random value
	lfp_in_stage u_in_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.random_value (random_value),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.word         (word)
	);

	// advance the pattern and decode the character
	lfp_sequencer u_sequencer (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word),
		.pattern    (pattern_flat),
		.period     (period_q),
		.step_valid (step_valid),
		.step_stall (step_stall),
		.step       (step)
	);

	// scale to milliamps and hold the result word
	lfp_current u_current (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_valid  (step_valid),
		.step_stall  (step_stall),
		.step        (step),
		.peak        (peak_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.led_on      (led_on),
		.led_current (led_current),
		.stopped     (stopped)
	);

endmodule

`default_nettype wire

@@ rtl/core/lfp_in_stage.sv @@
// Input register of the pattern player with reduction of the random value.
`default_nettype none

module lfp_in_stage
	import lfp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              operation,
	input  wire logic [RAND_W-1:0] random_value,
	output logic                   word_valid,
	input  wire logic              word_stall,
	output in_word_t               word
);

	// remainder by a small constant: reciprocal multiply, then one correction
	function automatic logic [RAND_W-1:0] rem_by(logic [RAND_W-1:0] r,
		logic [LEVEL_W-1:0] span, logic [RECIP_W-1:0] recip);
		logic [RAND_W+RECIP_W-1:0]  prod;
		logic [RAND_W-1:0]          quo;
		logic [RAND_W+LEVEL_W-1:0]  back;
		logic [RAND_W-1:0]          rem;
		prod = (RAND_W+RECIP_W)'(r) * (RAND_W+RECIP_W)'(recip);
		quo  = prod[RECIP_SHIFT +: RAND_W];
		back = (RAND_W+LEVEL_W)'(quo) * (RAND_W+LEVEL_W)'(span);
		rem  = r - back[RAND_W-1:0];
		if (rem >= RAND_W'(span))
			rem = rem - RAND_W'(span);
		return rem;
	endfunction

	logic              valid_s1;
	in_word_t          word_s1;
	in_word_t          word_d;
	logic [RAND_W-1:0] rem_level;
	logic [RAND_W-1:0] rem_branch;
	logic [RAND_W-1:0] rem_delay;
	logic              take;

	assign in_stall = valid_s1 && word_stall;
	assign take     = in_valid && !in_stall;

	always_comb begin
		rem_level          = rem_by(random_value, LEVEL_W'(LEVEL_SPAN), RECIP_LEVEL);
		rem_branch         = rem_by(random_value, LEVEL_W'(BRANCH_SPAN), RECIP_BRANCH);
		rem_delay          = rem_by(random_value, LEVEL_W'(DELAY_SPAN), RECIP_DELAY);
		word_d.op          = operation;
		word_d.lvl_rem     = rem_level[LEVEL_W-1:0];
		word_d.branch_home = rem_branch < RAND_W'(BRANCH_LIMIT);
		word_d.delay_rem   = rem_delay[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1 <= word_d;
		end
	end

	assign word_valid = valid_s1;
	assign word       = word_s1;

endmodule

`default_nettype wire

@@ rtl/core/lfp_sequencer.sv @@
// Pattern sequencer: position, pass toggle, delay count and level decode.
`default_nettype none

module lfp_sequencer
	import lfp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                word_valid,
	output logic                     word_stall,
	input  wire in_word_t            word,
	input  wire logic [PAT_BITS-1:0] pattern,
	input  wire logic [PERIOD_W-1:0] period,
	output logic                     step_valid,
	input  wire logic                step_stall,
	output step_t                    step
);

	logic [POS_W-1:0]   pos_q;
	logic               toggle_q;
	logic [DELAY_W-1:0] delay_q;
	logic               lit_q;

	logic [POS_W-1:0]   pos_n;
	logic               toggle_n;
	logic [DELAY_W-1:0] delay_n;
	logic               lit_n;
	logic [POS_W-1:0]   pos_adv;
	logic [CHAR_W-1:0]  ch;
	logic [LEVEL_W-1:0] level;
	logic               set_level;
	logic [15:0]        u_delay;
	step_t              step_n;

	logic  valid_s2;
	step_t step_s2;
	logic  fire;

	assign word_stall = valid_s2 && step_stall;
	assign fire       = word_valid && !word_stall;

	always_comb begin
		ch        = pattern[{pos_q, 3'b000} +: CHAR_W];
		pos_adv   = (pos_q == POS_W'(PATTERN_LENGTH - 1)) ? '0 : pos_q + 1'b1;
		u_delay   = 16'(6'(word.delay_rem) + 6'd1) * 16'(period);
		pos_n     = pos_q;
		toggle_n  = toggle_q;
		delay_n   = delay_q;
		lit_n     = lit_q;
		level     = '0;
		set_level = 1'b0;
		step_n.act     = ACT_KEEP;
		step_n.stopped = 1'b0;

		if (word.op) begin
			// restart; a running delay holds its count
			toggle_n   = 1'b0;
			lit_n      = 1'b1;
			pos_n      = '0;
			step_n.act = ACT_ZERO;
		end else if (delay_q != '0) begin
			delay_n = delay_q - 1'b1;
		end else begin
			unique case (ch) inside
				[CH_1:CH_9]: begin
					set_level = 1'b1;
					level     = (LEVEL_W'(ch[3:0]) << 3) + (LEVEL_W'(ch[3:0]) << 1);
				end
				CH_A: begin
					set_level = 1'b1;
					level     = LEVEL_W'(LEVEL_FULL);
				end
				CH_R: begin
					set_level = 1'b1;
					level     = word.lvl_rem + LEVEL_W'(LEVEL_BASE);
				end
				CH_DASH: begin
					set_level = 1'b1;
				end
				CH_S: begin
					lit_n          = 1'b0;
					step_n.act     = ACT_ZERO;
					step_n.stopped = 1'b1;
				end
				CH_B: begin
					pos_n = word.branch_home ? '0 : pos_adv;
				end
				CH_T: begin
					toggle_n = !toggle_q;
					pos_n    = toggle_q ? pos_adv : '0;
				end
				CH_W: begin
					pos_n   = pos_adv;
					delay_n = DELAY_W'(period >> 1);
				end
				CH_X: begin
					pos_n   = pos_adv;
					delay_n = DELAY_W'(period);
				end
				CH_Y: begin
					pos_n   = pos_adv;
					delay_n = DELAY_W'({period, 1'b0});
				end
				CH_Z: begin
					pos_n   = pos_adv;
					delay_n = DELAY_W'({period, 2'b00});
				end
				CH_U: begin
					pos_n   = pos_adv;
					delay_n = u_delay[DELAY_W-1:0];
				end
				default: begin
					pos_n = '0;
				end
			endcase
		end

		if (set_level) begin
			pos_n      = pos_adv;
			lit_n      = level != '0;
			step_n.act = ACT_LOAD;
		end

		step_n.gfrac = GAMMA_LUT[level];
		step_n.lit   = lit_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			toggle_q <= 1'b0;
			delay_q  <= '0;
			lit_q    <= 1'b1;
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				pos_q    <= pos_n;
				toggle_q <= toggle_n;
				delay_q  <= delay_n;
				lit_q    <= lit_n;
			end
			if (!word_stall) begin
				valid_s2 <= word_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			step_s2 <= step_n;
		end
	end

	assign step_valid = valid_s2;
	assign step       = step_s2;

	a_delay_counts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !word.op && delay_q != '0 |=> delay_q == $past(delay_q) - 1'b1)
		else $error("delay did not count down by one");

	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && step_n.stopped |=> pos_q == $past(pos_q) && !lit_q)
		else $error("stop moved the position or left the LED lit");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && word.op |=> pos_q == '0 && lit_q && !toggle_q)
		else $error("restart did not return to the pattern start");

endmodule

`default_nettype wire

@@ rtl/core/lfp_current.sv @@
// Output stage: scales the gamma fraction by the peak current and holds the result.
`default_nettype none

module lfp_current
	import lfp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step_valid,
	output logic                   step_stall,
	input  wire step_t             step,
	input  wire logic [PEAK_W-1:0] peak,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   led_on,
	output logic [PEAK_W-1:0]      led_current,
	output logic                   stopped
);

	localparam int PROD_W = GFRAC_W + PEAK_W;

	logic              valid_q;
	logic              led_on_q;
	logic [PEAK_W-1:0] led_current_q;
	logic              stopped_q;
	logic [PROD_W-1:0] prod;
	logic [PEAK_W-1:0] scaled;
	logic [PEAK_W-1:0] current_n;
	logic              fire;

	assign step_stall = valid_q && out_stall;
	assign fire       = step_valid && !step_stall;

	always_comb begin
		prod   = PROD_W'(step.gfrac) * PROD_W'(peak) + PROD_W'(Q_HALF);
		scaled = prod[Q_SHIFT +: PEAK_W];
		unique case (step.act)
			ACT_KEEP: current_n = led_current_q;
			ACT_ZERO: current_n = '0;
			ACT_LOAD: current_n = scaled;
			default:  current_n = led_current_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= 1'b0;
			led_current_q <= '0;
		end else begin
			if (!step_stall) begin
				valid_q <= step_valid;
			end
			if (fire) begin
				led_current_q <= current_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			led_on_q  <= step.lit;
			stopped_q <= step.stopped;
		end
	end

	assign out_valid   = valid_q;
	assign led_on      = led_on_q;
	assign led_current = led_current_q;
	assign stopped     = stopped_q;

	a_keep_current: assert property (@(posedge clk) disable iff (!arst_n)
		fire && step.act == ACT_KEEP |=> led_current_q == $past(led_current_q))
		else $error("current changed on a word that keeps it");

	a_stopped_dark: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && stopped_q |-> led_current_q == '0 && !led_on_q)
		else $error("stopped word shows a lit LED");

endmodule

`default_nettype wire
